// ----- design/ksat_pkg.sv -----
`timescale 1ns / 1ps

package ksat_pkg;

  // Default sizes of the clause store and of the variable space.
  localparam int unsigned DefMaxClauses  = 256;
  localparam int unsigned DefMaxLiterals = 8;
  localparam int unsigned DefNumVars     = 64;

  // Field widths fixed by the interface.
  localparam int unsigned LitW     = 8;
  localparam int unsigned AssignW  = 64;
  localparam int unsigned CountW   = 9;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EXACT_COUNT         = 2'd0,
    CFG_CLAUSE_COUNT        = 2'd1,
    CFG_LITERALS_PER_CLAUSE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic                      op;
    logic [7:0]                clause_index;
    logic [2:0]                literal_position;
    logic signed [LitW-1:0]    literal;
    logic [AssignW-1:0]        assignment;
  } ksat_in_t;

  typedef struct packed {
    logic [CountW-1:0] satisfied_count;
    logic              all_satisfied;
  } ksat_out_t;

endpackage

// ----- design/ksat_ram.sv -----
`timescale 1ns / 1ps

module ksat_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/ksat_clause_evaluator.sv -----
`timescale 1ns / 1ps

// Clause satisfaction counter for a CNF formula held in an on-chip clause store.
// A load request writes one signed literal into the store at clause *
// MAX_LITERALS + position, and returns no result. An evaluate request reads
// every literal of the active formula through the single read port of the store,
// one literal per cycle, clauses * literals in all, where clauses is clause_count
// limited to CLAUSE_DEPTH and literals is literals_per_clause limited to
// MAX_LITERALS. Requests are stalled while an evaluation is in progress. The
// result sits in an output register, so loads and a new evaluation may proceed
// while an earlier result still waits to be taken; an evaluation that finishes
// before then holds until the register is free. Configuration writes are
// accepted in every cycle and must only be made while the block is idle.

module ksat_clause_evaluator
  import ksat_pkg::*;
#(
  parameter int unsigned CLAUSE_DEPTH = DefMaxClauses,
  parameter int unsigned MAX_LITERALS = DefMaxLiterals,
  parameter int unsigned NUM_VARS     = DefNumVars
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ksat_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ksat_out_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned StoreDepth = CLAUSE_DEPTH * MAX_LITERALS;
  localparam int unsigned AddrW      = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  // Configuration registers.
  logic [3:0]        exact_cfg_q;
  logic [CountW-1:0] clauses_cfg_q;
  logic [3:0]        literals_cfg_q;

  // Sequencer state and the snapshot taken when an evaluation starts.
  state_e             state_q;
  logic [CountW-1:0]  nc_q;
  logic [3:0]         nl_q;
  logic [3:0]         exact_q;
  logic [AssignW-1:0] assign_q;
  logic [CountW-1:0]  clause_q;
  logic [3:0]         pos_q;
  logic [AddrW-1:0]   base_q;

  // Read return side.
  logic              rd_vld_q;
  logic              rd_last_q;
  logic [3:0]        trues_q;
  logic [CountW-1:0] count_q;

  logic              out_valid_q;
  ksat_out_t         out_data_q;

  logic              in_acc;
  logic              is_load;
  logic              load_in_range;
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic              ram_re;
  logic [AddrW-1:0]  ram_raddr;
  logic [LitW-1:0]   ram_rdata;

  logic [CountW-1:0] nc_d;
  logic [3:0]        nl_d;
  logic              last_pos;
  logic              last_clause;

  logic              lit_neg;
  logic [LitW-1:0]   lit_mag;
  logic              lit_known;
  logic              lit_bit;
  logic              lit_true;
  logic [3:0]        trues_sum;
  logic              clause_ok;
  logic              out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign is_load     = (op_e'(in_data_i.op) == OP_LOAD);
  assign cfg_ready_o = 1'b1;

  // A load outside the store is dropped.
  assign load_in_range = (32'(in_data_i.clause_index) < 32'(CLAUSE_DEPTH)) &&
                         (32'(in_data_i.literal_position) < 32'(MAX_LITERALS));
  assign ram_we    = in_acc && is_load && load_in_range;
  assign ram_waddr = AddrW'(32'(in_data_i.clause_index) * 32'(MAX_LITERALS) +
                            32'(in_data_i.literal_position));

  // The scan walks the store clause by clause, one literal per cycle.
  assign ram_re    = (state_q == ST_SCAN);
  assign ram_raddr = base_q + AddrW'(pos_q);

  ksat_ram #(
    .WIDTH(LitW),
    .DEPTH(StoreDepth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(in_data_i.literal),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Oversized counts saturate at the store dimensions.
  assign nc_d = (32'(clauses_cfg_q) > 32'(CLAUSE_DEPTH)) ? CountW'(CLAUSE_DEPTH) :
                clauses_cfg_q;
  assign nl_d = (32'(literals_cfg_q) > 32'(MAX_LITERALS)) ? 4'(MAX_LITERALS) :
                literals_cfg_q;

  assign last_pos    = (pos_q == nl_q - 4'd1);
  assign last_clause = (clause_q == nc_q - CountW'(1));

  // Truth of the literal returned by the store. The magnitude of the most
  // negative code is 128, which lies outside every variable range. Variables
  // beyond the assignment read as false, so their negation reads as true.
  assign lit_neg   = ram_rdata[LitW-1];
  assign lit_mag   = lit_neg ? LitW'(~ram_rdata + LitW'(1)) : ram_rdata;
  assign lit_known = (ram_rdata != '0) && (32'(lit_mag) <= 32'(NUM_VARS)) &&
                     (32'(lit_mag) <= 32'(AssignW));
  assign lit_bit   = lit_known ? assign_q[6'(lit_mag - LitW'(1))] : 1'b0;
  assign lit_true  = (ram_rdata != '0) && (lit_bit ^ lit_neg);

  assign trues_sum = trues_q + 4'(lit_true);
  assign clause_ok = (exact_q == 4'd0) ? (trues_sum != 4'd0) : (trues_sum == exact_q);

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exact_cfg_q    <= 4'd0;
      clauses_cfg_q  <= '0;
      literals_cfg_q <= 4'd3;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_EXACT_COUNT:         exact_cfg_q    <= cfg_data_i[3:0];
        CFG_CLAUSE_COUNT:        clauses_cfg_q  <= cfg_data_i;
        CFG_LITERALS_PER_CLAUSE: literals_cfg_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      nc_q        <= '0;
      nl_q        <= '0;
      exact_q     <= '0;
      assign_q    <= '0;
      clause_q    <= '0;
      pos_q       <= '0;
      base_q      <= '0;
      rd_vld_q    <= 1'b0;
      rd_last_q   <= 1'b0;
      trues_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      rd_vld_q  <= ram_re;
      rd_last_q <= ram_re && last_pos;

      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      // Return side: sum the literals of a clause and judge it on the last one.
      if (rd_vld_q) begin
        if (rd_last_q) begin
          trues_q <= '0;
          if (clause_ok) begin
            count_q <= count_q + CountW'(1);
          end
        end else begin
          trues_q <= trues_sum;
        end
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc && !is_load) begin
            nc_q     <= nc_d;
            nl_q     <= nl_d;
            exact_q  <= exact_cfg_q;
            assign_q <= in_data_i.assignment;
            clause_q <= '0;
            pos_q    <= '0;
            base_q   <= '0;
            trues_q  <= '0;
            count_q  <= '0;
            // With no clauses or empty clauses nothing can count.
            state_q  <= ((nc_d == '0) || (nl_d == 4'd0)) ? ST_DONE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (last_pos) begin
            pos_q    <= '0;
            clause_q <= clause_q + CountW'(1);
            base_q   <= base_q + AddrW'(MAX_LITERALS);
            if (last_clause) begin
              state_q <= ST_DRAIN;
            end
          end else begin
            pos_q <= pos_q + 4'd1;
          end
        end
        ST_DRAIN: begin
          // The final literal is folded into the count in this cycle.
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q                <= 1'b1;
            out_data_q.satisfied_count <= count_q;
            out_data_q.all_satisfied   <= (count_q == nc_q);
            state_q                    <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- design/ksat_chk.sv -----
`timescale 1ns / 1ps

module ksat_chk
  import ksat_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input ksat_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input ksat_out_t out_data_o
);

  logic eval_acc;
  logic load_acc;

  assign eval_acc = in_valid_i && !in_stall_o && (op_e'(in_data_i.op) == OP_EVAL);
  assign load_acc = in_valid_i && !in_stall_o && (op_e'(in_data_i.op) == OP_LOAD);

  // An accepted evaluation always makes the block busy.
  a_eval_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_acc |=> in_stall_o)
    else $error("evaluation accepted but next request not stalled");

  // A load never makes the block busy.
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_acc |=> !in_stall_o)
    else $error("load left the block busy");

  // A new result only appears as an evaluation ends.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without an evaluation in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result dropped or changed");

endmodule

bind ksat_clause_evaluator ksat_chk u_ksat_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
